FILE: rtl/core/mrohe_pkg.sv
`timescale 1ns / 1ps

package mrohe_pkg;

  // Geometry fixed by the field widths
  localparam int MAX_LEVELS   = 12;
  localparam int COEF_W       = 32;
  localparam int ARITY_W      = 5;
  localparam int LEVEL_W      = 4;
  localparam int OFFSET_W     = 19;
  localparam int ONE_HOT_W    = 30;
  localparam int PACK_W       = MAX_LEVELS * ARITY_W;
  localparam int CFG_ADDR_W   = 2;
  localparam int OUT_TDATA_W  = 64;

  // Divider: bits of quotient resolved per cycle, and divider steps per level
  localparam int DIV_BITS     = 8;
  localparam int DIV_STEPS    = COEF_W / DIV_BITS;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ARITY_PACK  = 2'd1;

  // Reset values of the configuration registers
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RST = 4'd1;
  localparam logic [PACK_W-1:0]  ARITY_PACK_RST  = 60'd74382032555280450;

  // One queued coefficient
  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              restart;
  } q_entry_t;

  // Queue head as seen by the encoder back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

FILE: rtl/core/mixed_radix_one_hot_encoder.sv
`timescale 1ns / 1ps

// Mixed-radix one-hot encoder. Each input beat carries one 32-bit coefficient;
// the block splits it into digits by the configured per-level arities (level 0
// first) and sends one output beat per level describing a one-hot field of
// arity-1 bits at a running bit offset, with tlast on the final level and tuser
// flagging a coefficient too large for the arities. A short input queue keeps
// accepting beats while the encoder works. Each level passes through the
// shared divider, which resolves 8 quotient bits a cycle, and then loads
// the output register once it is free; the next coefficient leaves the
// queue only after the final level is committed. Configuration writes
// must be made while the block is idle.

module mixed_radix_one_hot_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [mrohe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mrohe_pkg::PACK_W-1:0]          cfg_wdata,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mrohe_pkg::COEF_W-1:0]          in_tdata,  // [31:0] coefficient
  input  logic                                  in_tuser,  // [0] restart
  // Result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [3:0] level, [22:4] bit_offset, [27:23] field_width, [57:28] one_hot, rest 0
  output logic [mrohe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tuser  // [0] leftover_error
);
  import mrohe_pkg::*;

  q_entry_t in_entry;
  q_head_t  head;
  logic     pop;

  assign in_entry.coefficient = in_tdata;
  assign in_entry.restart     = in_tuser;

  mrohe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_entry  (in_entry),
    .head      (head),
    .pop       (pop)
  );

  mrohe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/mrohe_front.sv
`timescale 1ns / 1ps

module mrohe_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mrohe_pkg::q_entry_t in_entry,
  output mrohe_pkg::q_head_t  head,
  input  logic              pop
);
  import mrohe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  logic              do_pop;

  assign in_tready = (count_r != FULL_CNT);
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.entry = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_entry;
    end
  end

endmodule

FILE: rtl/core/mrohe_back.sv
`timescale 1ns / 1ps

module mrohe_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mrohe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mrohe_pkg::PACK_W-1:0]          cfg_wdata,
  input  mrohe_pkg::q_head_t                    head,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [mrohe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tuser
);
  import mrohe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [LEVEL_W-1:0] MAX_LVL = LEVEL_W'(MAX_LEVELS);

  // Configuration
  logic [LEVEL_W-1:0]   level_count_r;
  logic [PACK_W-1:0]    arity_pack_r;

  // Sequencer state
  logic [1:0]           state_r, state_nxt;
  logic [COEF_W-1:0]    quo_r, quo_nxt;
  logic [ARITY_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic [OFFSET_W-1:0]  offset_r, offset_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic                    out_last_r;
  logic                    out_err_r;

  logic [ARITY_W-1:0]   arity_raw [MAX_LEVELS];
  logic [ARITY_W-1:0]   arity;
  logic [ARITY_W-1:0]   width_m1;
  logic [LEVEL_W-1:0]   last_lvl;
  logic                 is_last;
  logic                 slot_free;
  logic                 commit;
  logic [DIV_BITS-1:0]  qbits;
  logic [ARITY_W-1:0]   div_rem;
  logic [ARITY_W:0]     trial;
  logic [ONE_HOT_W-1:0] one_hot;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      arity_pack_r  <= ARITY_PACK_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_LEVEL_COUNT) begin
        level_count_r <= cfg_wdata[LEVEL_W-1:0];
      end else if (cfg_addr == REG_ARITY_PACK) begin
        arity_pack_r <= cfg_wdata;
      end
    end
  end

  // Arity of the current level, small values forced to 2
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      arity_raw[i] = arity_pack_r[i*ARITY_W +: ARITY_W];
    end
  end

  assign arity    = (arity_raw[lvl_r] < 5'd2) ? 5'd2 : arity_raw[lvl_r];
  assign width_m1 = arity - 1'b1;

  // Effective level count, clamped to 1..MAX_LEVELS
  always_comb begin
    if (level_count_r == '0) begin
      last_lvl = '0;
    end else if (level_count_r > MAX_LVL) begin
      last_lvl = MAX_LVL - 1'b1;
    end else begin
      last_lvl = level_count_r - 1'b1;
    end
  end

  assign is_last = (lvl_r == last_lvl);

  // Restoring divide, eight quotient bits per cycle from the top of quo_r
  always_comb begin
    div_rem = rem_r;
    trial   = '0;
    qbits   = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {div_rem, quo_r[COEF_W-DIV_BITS+i]};
      if (trial >= {1'b0, arity}) begin
        trial    = trial - {1'b0, arity};
        qbits[i] = 1'b1;
      end
      div_rem = trial[ARITY_W-1:0];
    end
  end

  // Field contents from the final remainder (the digit)
  assign one_hot = (rem_r == '0) ? '0 : (ONE_HOT_W'(1) << (rem_r - 1'b1));

  assign slot_free = !out_valid_r || out_tready;
  assign commit    = (state_r == ST_EMIT) && slot_free;
  assign pop       = (state_r == ST_IDLE) && head.valid;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    lvl_nxt    = lvl_r;
    offset_nxt = offset_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          quo_nxt   = head.entry.coefficient;
          rem_nxt   = '0;
          step_nxt  = '0;
          lvl_nxt   = '0;
          if (head.entry.restart) begin
            offset_nxt = '0;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[COEF_W-DIV_BITS-1:0], qbits};
        rem_nxt  = div_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (commit) begin
          offset_nxt = offset_r + OFFSET_W'(width_m1);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt   = lvl_r + 1'b1;
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      offset_r <= '0;
    end else begin
      state_r  <= state_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    lvl_r  <= lvl_nxt;
  end

  // Output register
  assign out_valid_nxt = commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {6'd0, one_hot, width_m1, offset_r, lvl_r};
      out_last_r <= is_last;
      out_err_r  <= is_last && (quo_r != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

FILE: rtl/core/mrohe_checker.sv
`timescale 1ns / 1ps

module mrohe_assertions (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  cfg_we,
  input logic [mrohe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input logic [mrohe_pkg::PACK_W-1:0]          cfg_wdata,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [mrohe_pkg::COEF_W-1:0]          in_tdata,
  input logic                                  in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [mrohe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                  out_tlast,
  input logic                                  out_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // The oversize flag only rides on the final level of a coefficient
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("leftover error on a non-final level");

  // Field holds at most one set bit, and it lies inside the field
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[57:28])
      && ((out_tdata[57:28] >> out_tdata[27:23]) == 30'd0))
    else $error("malformed one-hot field");

  // Field width is never zero and level stays in range
  a_width_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:23] != 5'd0) && (out_tdata[3:0] < 4'd12))
    else $error("bad field width or level");

endmodule

bind mixed_radix_one_hot_encoder mrohe_assertions u_mrohe_assertions (.*);
